// File: design/rhls_pkg.sv
package rhls_pkg;

	// Number of channels the connected link steps through before wrapping.
	localparam int unsigned HOP_CHANNELS = 10;

	localparam int unsigned CHAN_W = 7;
	localparam int unsigned SLOT_W = 8;
	localparam int unsigned LOSS_W = 4;
	localparam int unsigned HIDX_W = 4;

	// Slot counter value loaded when a packet resynchronizes the link.
	localparam logic [SLOT_W-1:0] RESYNC_COUNT = 8'd3;

	// Channel table; entries beyond the tenth repeat the first six channels.
	localparam logic [CHAN_W-1:0] HOP_TABLE [16] = '{
		7'd4, 7'd12, 7'd18, 7'd27, 7'd36, 7'd41, 7'd47, 7'd54,
		7'd62, 7'd72, 7'd4, 7'd12, 7'd18, 7'd27, 7'd36, 7'd41
	};

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TX   = 2'd1,
		PH_RX   = 2'd2,
		PH_HOP  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_SET   = 2'd1,
		ACT_REPLY = 2'd2,
		ACT_FLUSH = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_TX_SLOT  = 3'd0,
		REG_RX_SLOT  = 3'd1,
		REG_HOP_SLOT = 3'd2,
		REG_CYCLE    = 3'd3,
		REG_LOSS     = 3'd4,
		REG_RELINK   = 3'd5
	} reg_addr_t;

	typedef struct packed {
		logic [SLOT_W-1:0] tx_slot_count;
		logic [SLOT_W-1:0] rx_slot_count;
		logic [SLOT_W-1:0] hop_slot_count;
		logic [SLOT_W-1:0] cycle_length;
		logic [LOSS_W-1:0] loss_limit;
		logic [CHAN_W-1:0] relink_channel;
	} cfg_t;

	typedef struct packed {
		action_t           action;
		logic [CHAN_W-1:0] channel;
		logic              connected;
		logic              refresh_remote;
	} result_t;

endpackage

// File: design/rhls_cfg.sv
module rhls_cfg
	import rhls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tx_slot_count  <= 8'd8;
			cfg_q.rx_slot_count  <= 8'd2;
			cfg_q.hop_slot_count <= 8'd10;
			cfg_q.cycle_length   <= 8'd12;
			cfg_q.loss_limit     <= 4'd6;
			cfg_q.relink_channel <= 7'd0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_TX_SLOT:  cfg_q.tx_slot_count  <= pwdata[SLOT_W-1:0];
				REG_RX_SLOT:  cfg_q.rx_slot_count  <= pwdata[SLOT_W-1:0];
				REG_HOP_SLOT: cfg_q.hop_slot_count <= pwdata[SLOT_W-1:0];
				REG_CYCLE:    cfg_q.cycle_length   <= pwdata[SLOT_W-1:0];
				REG_LOSS:     cfg_q.loss_limit     <= pwdata[LOSS_W-1:0];
				REG_RELINK:   cfg_q.relink_channel <= pwdata[CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[4:2])
			REG_TX_SLOT:  prdata = {24'd0, cfg_q.tx_slot_count};
			REG_RX_SLOT:  prdata = {24'd0, cfg_q.rx_slot_count};
			REG_HOP_SLOT: prdata = {24'd0, cfg_q.hop_slot_count};
			REG_CYCLE:    prdata = {24'd0, cfg_q.cycle_length};
			REG_LOSS:     prdata = {28'd0, cfg_q.loss_limit};
			REG_RELINK:   prdata = {25'd0, cfg_q.relink_channel};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// File: design/rhls_sched.sv
module rhls_sched
	import rhls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  logic    kind,
	input  logic    packet_ready,
	input  cfg_t    cfg,
	output result_t result
);

	logic [SLOT_W-1:0] slot_q, slot_d, slot_inc;
	phase_t            phase_q, phase_d;
	logic [HIDX_W-1:0] hidx_q, hidx_d;
	logic [HIDX_W:0]   hidx_inc;
	logic [LOSS_W-1:0] loss_q, loss_d;
	logic              link_q, link_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			phase_q <= PH_HOP;
			hidx_q  <= '0;
			loss_q  <= '0;
			link_q  <= 1'b0;
		end else if (fire) begin
			slot_q  <= slot_d;
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			loss_q  <= loss_d;
			link_q  <= link_d;
		end
	end

	always_comb begin
		slot_d   = slot_q;
		phase_d  = phase_q;
		hidx_d   = hidx_q;
		loss_d   = loss_q;
		link_d   = link_q;
		slot_inc = slot_q + 8'd1;
		hidx_inc = {1'b0, hidx_q} + 5'd1;
		result   = '{action: ACT_NONE, channel: '0, connected: 1'b0, refresh_remote: 1'b0};

		if (!kind) begin
			// Later matches take priority: hop over receive over transmit.
			if (slot_inc == cfg.tx_slot_count)
				phase_d = PH_TX;
			if (slot_inc == cfg.rx_slot_count)
				phase_d = PH_RX;
			if (slot_inc == cfg.hop_slot_count)
				phase_d = PH_HOP;
			slot_d = (slot_inc >= cfg.cycle_length) ? '0 : slot_inc;
		end else if (phase_q == PH_HOP) begin
			if (loss_q < cfg.loss_limit) begin
				loss_d = loss_q + 4'd1;
				link_d = 1'b1;
			end else begin
				link_d = 1'b0;
			end
			if (!link_d) begin
				hidx_d         = '0;
				result.channel = cfg.relink_channel;
			end else begin
				hidx_d = (hidx_inc >= 5'(HOP_CHANNELS)) ? '0 : hidx_inc[HIDX_W-1:0];
				result.channel        = HOP_TABLE[hidx_d];
				result.refresh_remote = 1'b1;
			end
			result.action = ACT_SET;
			phase_d       = PH_RX;
		end else if (phase_q == PH_RX || !link_q) begin
			if (packet_ready) begin
				loss_d        = '0;
				link_d        = 1'b1;
				phase_d       = PH_IDLE;
				slot_d        = RESYNC_COUNT;
				result.action = ACT_REPLY;
			end
		end else if (phase_q == PH_TX) begin
			result.action = ACT_FLUSH;
			phase_d       = PH_IDLE;
		end

		result.connected = link_d;
	end

endmodule

// File: design/rf_hopping_link_scheduler.sv
// Channel    Direction  Handshake                Contents
// s_*        in         s_tvalid / s_tready      one event word (tick or service)
// m_*        out        m_tvalid / m_tready      one result word per event word
// apb        in         psel & penable & pwrite  six configuration registers
//
// An event word is taken into the input register and its result word is offered from the result register.
// A new event word is accepted in every cycle while m_tready stays high.
// The input register and the result register hold two words between them: while a
// finished result waits for m_tready, one more event word is taken and then s_tready drops.
// Reset clears the schedule counters, sets the hop phase and loads the register defaults at once.
module rf_hopping_link_scheduler
	import rhls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] packet_ready, [7:1] zero
	input  logic [0:0]  s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] channel, [7] connected, [8] refresh_remote, [15:9] zero
	output logic [1:0]  m_tuser,   // [1:0] action
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg;
	result_t result;
	result_t result_q;

	logic valid_s1;
	logic kind_s1;
	logic ready_s1;
	logic out_valid_q;
	logic advance;

	// The staged event moves on whenever the result register is free or
	// is being emptied in this same cycle.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers carry no reset; valid bits qualify them.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1  <= s_tuser[0];
			ready_s1 <= s_tdata[0];
		end
		if (advance)
			result_q <= result;
	end

	rhls_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Schedule state updates on the same edge that captures the result.
	rhls_sched u_sched (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.kind        (kind_s1),
		.packet_ready(ready_s1),
		.cfg         (cfg),
		.result      (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.action;
	assign m_tdata  = {7'd0, result_q.refresh_remote, result_q.connected, result_q.channel};

endmodule

// File: design/rhls_checker.sv
module rhls_checker
	import rhls_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// Only a set-channel result names a channel.
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ACT_SET |-> m_tdata[6:0] == 7'd0)
		else $error("channel set on a non set-channel result");

	// Remote refresh only comes with a connected hop.
	a_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tuser == ACT_SET && m_tdata[7])
		else $error("refresh without a connected hop");

	// A reply always leaves the link connected.
	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_REPLY |-> m_tdata[7] && m_tdata[8] == 1'b0)
		else $error("reply while disconnected");

endmodule

bind rf_hopping_link_scheduler rhls_checker u_rhls_checker (.*);
